### src/mscf_pkg.sv
// Package for the motor speed command framer.
// Holds shared constants, codes, state and command types and the slot map; no dependencies.
package mscf_pkg;

  localparam int MOTORS      = 4;
  localparam int IN_CHANNELS = 4;
  localparam int CHECK_CH    = (MOTORS < IN_CHANNELS) ? MOTORS : IN_CHANNELS;
  localparam int SLOT_W      = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  // Byte positions inside one command sequence.
  localparam int FR_CSUM_I = 2 * MOTORS + 3;
  localparam int IDX_W     = $clog2(FR_CSUM_I + 1);
  typedef logic [IDX_W-1:0] idx_t;
  localparam idx_t FR_START = idx_t'(0);
  localparam idx_t FR_SPEED = idx_t'(1);
  localparam idx_t FR_RPM   = idx_t'(2);
  localparam idx_t FR_SEC   = idx_t'(2 * MOTORS + 2);
  localparam idx_t FR_CSUM  = idx_t'(FR_CSUM_I);

  localparam logic [7:0]  CMD_START    = 8'h40;
  localparam logic [7:0]  CMD_SPEED    = 8'h02;
  localparam logic [7:0]  CMD_STOP     = 8'h60;
  localparam logic [7:0]  CMD_CLEAR    = 8'h80;
  localparam logic [7:0]  SECURITY     = 8'h00;
  localparam logic [15:0] BASE_RPM     = 16'd1000;
  localparam logic [16:0] START_MARGIN = 17'd50;
  localparam logic [7:0]  STATUS_MASK  = 8'h0F;

  localparam logic [3:0] ST_STOPPED_A = 4'd1;
  localparam logic [3:0] ST_STOPPED_B = 4'd5;
  localparam logic [3:0] ST_RUNNING_A = 4'd2;
  localparam logic [3:0] ST_RUNNING_B = 4'd4;

  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [2:0] {
    REG_MIN_PERIOD    = 3'd0,
    REG_MAX_PERIOD    = 3'd1,
    REG_TOP_RPM       = 3'd2,
    REG_ACTIVE_MOTORS = 3'd3,
    REG_ORDER_MODE    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DIV,
    S_WRITE,
    S_SETUP,
    S_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic mul_go;
    logic div_go;
    logic slot_wr;
    logic emit_init;
    logic emit_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic ch_done;
    logic ch_fail;
    logic degen;
    logic div_done;
    logic out_free;
    logic emit_last;
    logic running;
  } dp_st_t;

  // Channel to motor slot assignment for the two order modes.
  function automatic logic [2:0] slot_map(input logic ord, input logic [1:0] ch);
    logic [2:0] s;
    s = 3'd0;
    unique case ({ord, ch})
      3'b000: s = 3'd0;
      3'b001: s = 3'd2;
      3'b010: s = 3'd1;
      3'b011: s = 3'd3;
      3'b100: s = 3'd1;
      3'b101: s = 3'd3;
      3'b110: s = 3'd0;
      3'b111: s = 3'd2;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

### src/mscf_if.sv
// Channel interfaces for the motor speed command framer.
// Depends on nothing; carries valid, ready and the payload of each word.
interface mscf_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] period_a;
  logic [15:0] period_b;
  logic [15:0] period_c;
  logic [15:0] period_d;
  logic [7:0]  status_byte;

  modport source (output valid, output opcode, output period_a, output period_b,
                  output period_c, output period_d, output status_byte, input ready);
  modport sink (input valid, input opcode, input period_a, input period_b,
                input period_c, input period_d, input status_byte, output ready);
endinterface

interface mscf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_transfer;
  logic       last;

  modport source (output valid, output out_byte, output end_of_transfer, output last,
                  input ready);
  modport sink (input valid, input out_byte, input end_of_transfer, input last,
                output ready);
endinterface

### src/mscf_div.sv
// Restoring divider for the rpm scaling: one quotient bit per cycle.
// Depends on mscf_pkg; the quotient must fit in 16 bits (num[31:16] < den).
module mscf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [15:0] quot,
  output logic        rem_nz
);

  logic [15:0] rem_r;
  logic [15:0] sh_r;
  logic [15:0] quot_r;
  logic        busy_r;
  logic        done_r;
  logic [mscf_pkg::DIV_CNT_W-1:0] cnt_r;

  logic [16:0] trial;
  logic        fits;

  assign trial = {rem_r, sh_r[15]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= mscf_pkg::DIV_CNT_W'(mscf_pkg::DIV_STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == mscf_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num[31:16];
      sh_r   <= num[15:0];
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? 16'(trial - {1'b0, den}) : trial[15:0];
      sh_r   <= {sh_r[14:0], 1'b0};
      quot_r <= {quot_r[14:0], fits};
    end
  end

  assign done   = done_r;
  assign quot   = quot_r;
  assign rem_nz = rem_r != 16'd0;

endmodule

### src/mscf_dpath.sv
// Datapath of the framer: registers, scaling, slot store and byte sequencer.
// Depends on mscf_pkg and mscf_div; driven by commands from mscf_ctrl.
module mscf_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  mscf_pkg::ctl_cmd_t cmd,
  output mscf_pkg::dp_st_t   st,
  input  logic               in_opcode,
  input  logic [15:0]        in_period_a,
  input  logic [15:0]        in_period_b,
  input  logic [15:0]        in_period_c,
  input  logic [15:0]        in_period_d,
  input  logic [7:0]         in_status_byte,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_eot,
  output logic               out_last
);

  logic [15:0] min_r, max_r, top_r;
  logic [2:0]  act_r;
  logic        ord_r;

  logic [15:0] per_r [mscf_pkg::IN_CHANNELS];
  logic [2:0]  ch_r;
  logic        running_r;
  logic [15:0] slot_r [mscf_pkg::MOTORS];
  logic [31:0] prod_r;

  mscf_pkg::idx_t idx_r;
  logic           stop_mode_r;
  logic [7:0]     csum_r;

  logic       ov_r, oeot_r, olast_r;
  logic [7:0] ob_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= 16'd1100;
      max_r <= 16'd1900;
      top_r <= 16'd11000;
      act_r <= 3'd4;
      ord_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (mscf_pkg::cfg_reg_t'(cfg_index))
        mscf_pkg::REG_MIN_PERIOD:    min_r <= cfg_wdata;
        mscf_pkg::REG_MAX_PERIOD:    max_r <= cfg_wdata;
        mscf_pkg::REG_TOP_RPM:       top_r <= cfg_wdata;
        mscf_pkg::REG_ACTIVE_MOTORS: act_r <= cfg_wdata[2:0];
        mscf_pkg::REG_ORDER_MODE:    ord_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Channel checking and scaling.
  logic [2:0]  n_act;
  logic [15:0] cur_per, clamped, offset, scale, den, quot, rpm_new;
  logic        scale_up, div_done, rem_nz;
  logic [2:0]  slot_sel;

  assign n_act    = (act_r > 3'(mscf_pkg::CHECK_CH)) ? 3'(mscf_pkg::CHECK_CH) : act_r;
  assign cur_per  = per_r[ch_r[1:0]];
  assign clamped  = (cur_per < min_r) ? min_r : ((cur_per > max_r) ? max_r : cur_per);
  assign offset   = clamped - min_r;
  assign scale_up = top_r >= mscf_pkg::BASE_RPM;
  assign scale    = scale_up ? (top_r - mscf_pkg::BASE_RPM) : (mscf_pkg::BASE_RPM - top_r);
  assign den      = max_r - min_r;
  assign slot_sel = mscf_pkg::slot_map(ord_r, ch_r[1:0]);

  mscf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .num   (prod_r),
    .den   (den),
    .done  (div_done),
    .quot  (quot),
    .rem_nz(rem_nz)
  );

  // A downward scale rounds the magnitude up, which keeps the floor rule.
  always_comb begin
    if (max_r <= min_r) begin
      rpm_new = mscf_pkg::BASE_RPM;
    end else if (scale_up) begin
      rpm_new = mscf_pkg::BASE_RPM + quot;
    end else begin
      rpm_new = mscf_pkg::BASE_RPM - (quot + 16'(rem_nz));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod_r <= 32'(offset) * 32'(scale);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !in_opcode) begin
      per_r[0] <= in_period_a;
      per_r[1] <= in_period_b;
      per_r[2] <= in_period_c;
      per_r[3] <= in_period_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
    end else if (cmd.accept) begin
      ch_r <= '0;
    end else if (cmd.slot_wr) begin
      ch_r <= ch_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mscf_pkg::MOTORS; i++) begin
        slot_r[i] <= '0;
      end
    end else if (cmd.slot_wr && (4'(slot_sel) < 4'(mscf_pkg::MOTORS))) begin
      slot_r[slot_sel[mscf_pkg::SLOT_W-1:0]] <= rpm_new;
    end
  end

  // Running flag: set by a start, moved only by a status sync otherwise.
  logic [3:0] nib;
  assign nib = 4'(in_status_byte & mscf_pkg::STATUS_MASK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
    end else if (cmd.accept && in_opcode) begin
      case (nib) inside
        mscf_pkg::ST_STOPPED_A, mscf_pkg::ST_STOPPED_B: running_r <= 1'b0;
        mscf_pkg::ST_RUNNING_A, mscf_pkg::ST_RUNNING_B: running_r <= 1'b1;
        default: ;
      endcase
    end else if (cmd.emit_init && st.ch_done) begin
      running_r <= 1'b1;
    end
  end

  // Byte sequencer.
  mscf_pkg::idx_t          rel;
  logic [mscf_pkg::SLOT_W-1:0] rpm_slot;
  logic [15:0]             rpm_word;
  logic [7:0]              cur_byte;
  logic                    cur_eot, cur_last;

  assign rel      = idx_r - mscf_pkg::FR_RPM;
  assign rpm_slot = rel[mscf_pkg::SLOT_W:1];
  assign rpm_word = slot_r[rpm_slot];

  always_comb begin
    cur_byte = 8'd0;
    cur_eot  = 1'b0;
    cur_last = 1'b0;
    if (stop_mode_r) begin
      cur_eot = 1'b1;
      if (idx_r == mscf_pkg::FR_START) begin
        cur_byte = mscf_pkg::CMD_STOP;
      end else begin
        cur_byte = mscf_pkg::CMD_CLEAR;
        cur_last = 1'b1;
      end
    end else if (idx_r == mscf_pkg::FR_START) begin
      cur_byte = mscf_pkg::CMD_START;
      cur_eot  = 1'b1;
    end else if (idx_r == mscf_pkg::FR_SPEED) begin
      cur_byte = mscf_pkg::CMD_SPEED;
    end else if (idx_r == mscf_pkg::FR_SEC) begin
      cur_byte = mscf_pkg::SECURITY;
    end else if (idx_r == mscf_pkg::FR_CSUM) begin
      cur_byte = csum_r;
      cur_eot  = 1'b1;
      cur_last = 1'b1;
    end else begin
      cur_byte = rel[0] ? rpm_word[7:0] : rpm_word[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      stop_mode_r <= 1'b0;
    end else if (cmd.emit_init) begin
      stop_mode_r <= !st.ch_done;
      idx_r       <= (st.ch_done && running_r) ? mscf_pkg::FR_SPEED : mscf_pkg::FR_START;
    end else if (cmd.emit_load) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      csum_r <= '0;
    end else if (cmd.emit_load && !stop_mode_r && idx_r != mscf_pkg::FR_START) begin
      csum_r <= csum_r ^ cur_byte;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      ob_r    <= cur_byte;
      oeot_r  <= cur_eot;
      olast_r <= cur_last;
    end
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_eot   = oeot_r;
  assign out_last  = olast_r;

  always_comb begin
    st.ch_done   = ch_r >= n_act;
    st.ch_fail   = {1'b0, cur_per} <= ({1'b0, min_r} + mscf_pkg::START_MARGIN);
    st.degen     = max_r <= min_r;
    st.div_done  = div_done;
    st.out_free  = !ov_r || out_ready;
    st.emit_last = cur_last;
    st.running   = running_r;
  end

endmodule

### src/mscf_ctrl.sv
// Controller state machine of the framer.
// Depends on mscf_pkg; issues commands to mscf_dpath and reads its status.
module mscf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_opcode,
  output logic               in_ready,
  input  mscf_pkg::dp_st_t   st,
  output mscf_pkg::ctl_cmd_t cmd
);

  mscf_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mscf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mscf_pkg::S_IDLE: begin
        if (in_valid && !in_opcode) state_nxt = mscf_pkg::S_CHECK;
      end
      mscf_pkg::S_CHECK: begin
        if (st.ch_done || st.ch_fail) state_nxt = mscf_pkg::S_SETUP;
        else if (st.degen)            state_nxt = mscf_pkg::S_WRITE;
        else                          state_nxt = mscf_pkg::S_MUL;
      end
      mscf_pkg::S_MUL:   state_nxt = mscf_pkg::S_DIV;
      mscf_pkg::S_DIV: begin
        if (st.div_done) state_nxt = mscf_pkg::S_WRITE;
      end
      mscf_pkg::S_WRITE: state_nxt = mscf_pkg::S_CHECK;
      mscf_pkg::S_SETUP: begin
        if (st.ch_done || st.running) state_nxt = mscf_pkg::S_EMIT;
        else                          state_nxt = mscf_pkg::S_IDLE;
      end
      mscf_pkg::S_EMIT: begin
        if (st.out_free && st.emit_last) state_nxt = mscf_pkg::S_IDLE;
      end
      default: state_nxt = mscf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      mscf_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      mscf_pkg::S_CHECK: begin
        cmd.mul_go = !st.ch_done && !st.ch_fail && !st.degen;
      end
      mscf_pkg::S_MUL:   cmd.div_go  = 1'b1;
      mscf_pkg::S_DIV:   ;
      mscf_pkg::S_WRITE: cmd.slot_wr = 1'b1;
      mscf_pkg::S_SETUP: cmd.emit_init = st.ch_done || st.running;
      mscf_pkg::S_EMIT:  cmd.emit_load = st.out_free;
      default: ;
    endcase
  end

endmodule

### src/motor_speed_command_framer_unit.sv
// Top level of the motor speed command framer.
// Depends on mscf_pkg, mscf_if, mscf_ctrl, mscf_dpath and mscf_div.
//
// Usage: the input channel in_ch carries one word per update, either a set of
// four pulse periods (opcode 0) or an observed status byte (opcode 1). The
// result channel out_ch carries the command bytes for the motor controller,
// one byte per word, with end_of_transfer marking the end of each bus transfer
// and last marking the final byte caused by one input word. Registers are
// written through cfg_wr_en, cfg_index and cfg_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce. A status
// word is taken while idle and produces no bytes. A period set is worked
// through one channel at a time: each converted channel passes through check,
// multiply, the 16-step shared restoring divider and slot write (check and
// slot write only when the scale is degenerate). Then up to twelve bytes leave
// at one per cycle while the receiver is ready; the last byte may still wait
// in the output register while the next word is accepted.
// Reset (synchronous, rst_n low) restores the default registers, clears the
// running flag and all slot speeds, and empties the output register. When the
// receiver stalls, the held byte stays on out_ch and the sequencer waits.
module motor_speed_command_framer_unit (
  input  logic               clk,
  input  logic               rst_n,
  mscf_in_if.sink            in_ch,
  mscf_out_if.source         out_ch,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  mscf_pkg::ctl_cmd_t cmd;
  mscf_pkg::dp_st_t   st;
  logic               in_ready;

  assign in_ch.ready = in_ready;

  // The controller sequences the work; the datapath holds the data registers.
  mscf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_opcode(in_ch.opcode),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  mscf_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .in_opcode     (in_ch.opcode),
    .in_period_a   (in_ch.period_a),
    .in_period_b   (in_ch.period_b),
    .in_period_c   (in_ch.period_c),
    .in_period_d   (in_ch.period_d),
    .in_status_byte(in_ch.status_byte),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_byte      (out_ch.out_byte),
    .out_eot       (out_ch.end_of_transfer),
    .out_last      (out_ch.last)
  );

endmodule
